// ===== design/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg : shared types and constants of the block bitmap allocator
// Field widths, result status codes, microcode control word layout,
// sequencer condition codes and the program addresses of the control store.
// ----------------------------------------------------------------------------
package bba_pkg;

	// disk geometry and list depth
	localparam int NUM_BLOCKS = 64;
	localparam int MAX_LIST   = 32;

	// field widths
	localparam int CMD_W      = 2;
	localparam int BLOCK_W    = 6;
	localparam int LEN_W      = 7;
	localparam int STATUS_W   = 3;
	localparam int CUR_W      = BLOCK_W + 1;
	localparam int END_W      = LEN_W + 1;
	localparam int LIST_AW    = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
	localparam int CNT_W      = $clog2(MAX_LIST + 1);
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 8;
	localparam int PC_W       = 5;

	typedef logic [PC_W-1:0] pc_t;

	// request kinds
	typedef enum logic [CMD_W-1:0] {
		CMD_CONTIG = 2'd0,
		CMD_OPEN   = 2'd1,
		CMD_LIST   = 2'd2,
		CMD_LINKED = 2'd3
	} cmd_t;

	// result status
	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_CONFLICT   = 3'd1,
		ST_FIRST_BUSY = 3'd2,
		ST_SHORT      = 3'd3,
		ST_PENDING    = 3'd4,
		ST_RANGE      = 3'd5,
		ST_SEQ        = 3'd6
	} status_t;

	// datapath actions
	typedef enum logic [3:0] {
		A_NOP,
		A_ACCEPT,
		A_INC,
		A_LOAD_START,
		A_SET_INC,
		A_LINK_STEP,
		A_OPEN,
		A_PUSH,
		A_IDX,
		A_RD,
		A_RD_EMIT,
		A_CLOSE
	} act_t;

	// result source
	typedef enum logic [2:0] {
		E_NONE,
		E_CONST,
		E_CUR,
		E_HOLD,
		E_LINK_LAST,
		E_PIDX,
		E_MEM
	} emit_t;

	// branch conditions
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_DISPATCH,
		C_CONT_BAD,
		C_LINK_BAD,
		C_ST_OOR,
		C_CUR_BUSY,
		C_CUR_MORE,
		C_LINK_DONE,
		C_FIN,
		C_LIST_BAD,
		C_CONFLICT,
		C_RD_MORE
	} cond_t;

	// one microcode word
	typedef struct packed {
		act_t    act;
		emit_t   emit;
		status_t est;
		cond_t   cond;
		pc_t     tgt;
		cond_t   brk;
		pc_t     brk_tgt;
	} ctrl_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic fire;
		cmd_t cmd;
		logic list_open;
		logic cont_bad;
		logic link_bad;
		logic st_oor;
		logic cur_busy;
		logic cur_more;
		logic link_done;
		logic fin;
		logic list_bad;
		logic conflict;
		logic rd_more;
		logic stall;
	} flags_t;

	// program addresses
	localparam pc_t P_IDLE    = 5'd0;
	localparam pc_t P_RANGE   = 5'd1;
	localparam pc_t P_CONF    = 5'd2;
	localparam pc_t P_FBUSY   = 5'd3;
	localparam pc_t P_SEQ     = 5'd4;
	localparam pc_t P_CT0     = 5'd5;
	localparam pc_t P_CT1     = 5'd6;
	localparam pc_t P_CT2     = 5'd7;
	localparam pc_t P_CT3     = 5'd8;
	localparam pc_t P_CT4     = 5'd9;
	localparam pc_t P_OP0     = 5'd10;
	localparam pc_t P_OP1     = 5'd11;
	localparam pc_t P_OP2     = 5'd12;
	localparam pc_t P_LK0     = 5'd13;
	localparam pc_t P_LK1     = 5'd14;
	localparam pc_t P_LK2     = 5'd15;
	localparam pc_t P_LK3     = 5'd16;
	localparam pc_t P_LK4     = 5'd17;
	localparam pc_t P_LS0     = 5'd18;
	localparam pc_t P_LS1     = 5'd19;
	localparam pc_t P_LS2     = 5'd20;
	localparam pc_t P_LS3     = 5'd21;
	localparam pc_t P_LS4     = 5'd22;
	localparam pc_t P_LS5     = 5'd23;
	localparam pc_t P_LS6     = 5'd24;
	localparam pc_t P_LS7     = 5'd25;
	localparam pc_t P_LSCONF  = 5'd26;
	localparam pc_t P_LSDROP  = 5'd27;

endpackage

// ===== design/bba_ucode_rom.sv =====
// ----------------------------------------------------------------------------
// bba_ucode_rom : control store of the allocator sequencer
// One control word per program step: datapath action, result source,
// constant status, a normal branch and an early-exit branch.
// ----------------------------------------------------------------------------
module bba_ucode_rom (
	input  bba_pkg::pc_t   pc,
	output bba_pkg::ctrl_t word
);
	import bba_pkg::*;

	function automatic ctrl_t mk(act_t a, emit_t e, status_t s, cond_t c, pc_t t,
			cond_t b, pc_t bt);
		ctrl_t w;
		w.act     = a;
		w.emit    = e;
		w.est     = s;
		w.cond    = c;
		w.tgt     = t;
		w.brk     = b;
		w.brk_tgt = bt;
		return w;
	endfunction

	// program table
	always_comb begin
		unique case (pc)
			// wait for a request beat, then dispatch on its kind
			P_IDLE:   word = mk(A_ACCEPT, E_NONE, ST_OK, C_DISPATCH, P_IDLE, C_NEVER, P_IDLE);
			// single-beat error and refusal results
			P_RANGE:  word = mk(A_NOP, E_CONST, ST_RANGE, C_ALWAYS, P_IDLE, C_NEVER, P_IDLE);
			P_CONF:   word = mk(A_NOP, E_CONST, ST_CONFLICT, C_ALWAYS, P_IDLE, C_NEVER, P_IDLE);
			P_FBUSY:  word = mk(A_NOP, E_CONST, ST_FIRST_BUSY, C_ALWAYS, P_IDLE, C_NEVER,
				P_IDLE);
			P_SEQ:    word = mk(A_NOP, E_CONST, ST_SEQ, C_ALWAYS, P_IDLE, C_NEVER, P_IDLE);
			// contiguous: range check, busy scan, then allocate and report
			P_CT0:    word = mk(A_NOP, E_NONE, ST_OK, C_NEVER, P_IDLE, C_CONT_BAD, P_RANGE);
			P_CT1:    word = mk(A_INC, E_NONE, ST_OK, C_CUR_MORE, P_CT1, C_CUR_BUSY, P_CONF);
			P_CT2:    word = mk(A_LOAD_START, E_NONE, ST_OK, C_NEVER, P_IDLE, C_NEVER, P_IDLE);
			P_CT3:    word = mk(A_SET_INC, E_CUR, ST_OK, C_CUR_MORE, P_CT3, C_NEVER, P_IDLE);
			P_CT4:    word = mk(A_NOP, E_NONE, ST_OK, C_ALWAYS, P_IDLE, C_NEVER, P_IDLE);
			// indexed open
			P_OP0:    word = mk(A_NOP, E_NONE, ST_OK, C_NEVER, P_IDLE, C_ST_OOR, P_RANGE);
			P_OP1:    word = mk(A_NOP, E_NONE, ST_OK, C_NEVER, P_IDLE, C_CUR_BUSY, P_FBUSY);
			P_OP2:    word = mk(A_OPEN, E_CONST, ST_PENDING, C_ALWAYS, P_IDLE, C_NEVER, P_IDLE);
			// linked: take the start block, then free blocks upward
			P_LK0:    word = mk(A_NOP, E_NONE, ST_OK, C_NEVER, P_IDLE, C_LINK_BAD, P_RANGE);
			P_LK1:    word = mk(A_NOP, E_NONE, ST_OK, C_NEVER, P_IDLE, C_CUR_BUSY, P_FBUSY);
			P_LK2:    word = mk(A_LINK_STEP, E_NONE, ST_OK, C_NEVER, P_IDLE, C_NEVER, P_IDLE);
			P_LK3:    word = mk(A_LINK_STEP, E_HOLD, ST_OK, C_ALWAYS, P_LK3, C_LINK_DONE,
				P_LK4);
			P_LK4:    word = mk(A_NOP, E_LINK_LAST, ST_OK, C_ALWAYS, P_IDLE, C_NEVER, P_IDLE);
			// indexed list block
			P_LS0:    word = mk(A_NOP, E_NONE, ST_OK, C_NEVER, P_IDLE, C_LIST_BAD, P_LSDROP);
			P_LS1:    word = mk(A_PUSH, E_NONE, ST_OK, C_FIN, P_LS3, C_NEVER, P_IDLE);
			P_LS2:    word = mk(A_NOP, E_CONST, ST_PENDING, C_ALWAYS, P_IDLE, C_NEVER, P_IDLE);
			P_LS3:    word = mk(A_NOP, E_NONE, ST_OK, C_NEVER, P_IDLE, C_CONFLICT, P_LSCONF);
			P_LS4:    word = mk(A_IDX, E_PIDX, ST_OK, C_NEVER, P_IDLE, C_NEVER, P_IDLE);
			P_LS5:    word = mk(A_RD, E_NONE, ST_OK, C_NEVER, P_IDLE, C_NEVER, P_IDLE);
			P_LS6:    word = mk(A_RD_EMIT, E_MEM, ST_OK, C_RD_MORE, P_LS5, C_NEVER, P_IDLE);
			P_LS7:    word = mk(A_CLOSE, E_NONE, ST_OK, C_ALWAYS, P_IDLE, C_NEVER, P_IDLE);
			P_LSCONF: word = mk(A_CLOSE, E_CONST, ST_CONFLICT, C_ALWAYS, P_IDLE, C_NEVER,
				P_IDLE);
			P_LSDROP: word = mk(A_CLOSE, E_CONST, ST_RANGE, C_ALWAYS, P_IDLE, C_NEVER, P_IDLE);
			default:  word = mk(A_NOP, E_NONE, ST_OK, C_ALWAYS, P_IDLE, C_NEVER, P_IDLE);
		endcase
	end

endmodule

// ===== design/bba_seq.sv =====
// ----------------------------------------------------------------------------
// bba_seq : microcode sequencer of the allocator
// Step counter over the control store with an early-exit branch, a normal
// branch, request dispatch and a hold while a due result is blocked.
// ----------------------------------------------------------------------------
module bba_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  bba_pkg::flags_t flags,
	output bba_pkg::ctrl_t  word,
	output logic            go
);
	import bba_pkg::*;

	pc_t  pc_q;
	pc_t  pc_d;
	logic brk_hit;
	logic cond_hit;

	bba_ucode_rom u_rom (
		.pc   (pc_q),
		.word (word)
	);

	// condition select
	function automatic logic test(cond_t c, flags_t f);
		logic r;
		unique case (c)
			C_NEVER:     r = 1'b0;
			C_ALWAYS:    r = 1'b1;
			C_DISPATCH:  r = 1'b0;
			C_CONT_BAD:  r = f.cont_bad;
			C_LINK_BAD:  r = f.link_bad;
			C_ST_OOR:    r = f.st_oor;
			C_CUR_BUSY:  r = f.cur_busy;
			C_CUR_MORE:  r = f.cur_more;
			C_LINK_DONE: r = f.link_done;
			C_FIN:       r = f.fin;
			C_LIST_BAD:  r = f.list_bad;
			C_CONFLICT:  r = f.conflict;
			C_RD_MORE:   r = f.rd_more;
			default:     r = 1'b0;
		endcase
		return r;
	endfunction

	// entry point of each request kind
	function automatic pc_t dispatch(cmd_t cmd, logic open);
		pc_t p;
		priority if (cmd == CMD_LIST) begin
			p = open ? P_LS0 : P_SEQ;
		end else if (open) begin
			p = P_SEQ;
		end else if (cmd == CMD_CONTIG) begin
			p = P_CT0;
		end else if (cmd == CMD_OPEN) begin
			p = P_OP0;
		end else begin
			p = P_LK0;
		end
		return p;
	endfunction

	// branch evaluation
	always_comb begin
		brk_hit  = test(word.brk, flags);
		cond_hit = test(word.cond, flags);
		go       = !flags.stall && !brk_hit;
		priority if (flags.stall) begin
			pc_d = pc_q;
		end else if (brk_hit) begin
			pc_d = word.brk_tgt;
		end else if (word.cond == C_DISPATCH) begin
			pc_d = flags.fire ? dispatch(flags.cmd, flags.list_open) : pc_q;
		end else if (cond_hit) begin
			pc_d = word.tgt;
		end else begin
			pc_d = pc_q + pc_t'(1);
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= P_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

`ifndef NO_ASSERTIONS
	// a held result beat freezes the program
	a_stall_holds_pc: assert property (@(posedge clk) disable iff (!arst_n)
		flags.stall |=> pc_q == $past(pc_q))
		else $error("sequencer advanced during an output stall");
`endif

endmodule

// ===== design/bba_dp.sv =====
// ----------------------------------------------------------------------------
// bba_dp : allocator datapath
// Allocation bitmap, open list state and list memory, scan cursor and
// counters, request capture and the result output register.
// ----------------------------------------------------------------------------
module bba_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	// request beat
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bba_pkg::IN_DATA_W-1:0]    s_tdata,  // start_block, length, list_block
	input  logic [bba_pkg::CMD_W-1:0]        s_tuser,  // cmd
	input  logic                             s_tlast,  // list_last
	// result beat
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bba_pkg::OUT_DATA_W-1:0]   m_tdata,  // block
	output logic [bba_pkg::STATUS_W-1:0]     m_tuser,  // status
	output logic                             m_tlast,  // last
	// sequencer
	input  bba_pkg::ctrl_t                   word,
	input  logic                             go,
	output bba_pkg::flags_t                  flags
);
	import bba_pkg::*;

	logic [NUM_BLOCKS-1:0] map_q;
	logic [NUM_BLOCKS-1:0] pmap_q;
	logic                  list_open_q;
	logic                  conflict_q;
	logic [CNT_W-1:0]      pcount_q;
	logic [CNT_W-1:0]      rd_ptr_q;
	logic [BLOCK_W-1:0]    pidx_q;
	logic [BLOCK_W-1:0]    st_q;
	logic [BLOCK_W-1:0]    blk_q;
	logic [BLOCK_W-1:0]    hold_q;
	logic [BLOCK_W-1:0]    rd_data_q;
	logic [LEN_W-1:0]      len_q;
	logic [LEN_W-1:0]      cnt_q;
	logic                  fin_q;
	logic [CUR_W-1:0]      cursor_q;
	logic [END_W-1:0]      end_q;
	logic [BLOCK_W-1:0]    list_mem [MAX_LIST];

	logic                  out_valid_q;
	status_t               out_status_q;
	logic [BLOCK_W-1:0]    out_block_q;
	logic                  out_last_q;

	logic [BLOCK_W-1:0]    in_start;
	logic [LEN_W-1:0]      in_len;
	logic [BLOCK_W-1:0]    in_blk;
	logic                  fire;
	logic                  cur_busy;
	logic                  cur_more;
	logic                  st_oor;
	logic                  rd_more;
	logic                  wants_emit;
	logic                  stall;
	logic                  emit_now;
	logic [BLOCK_W-1:0]    cur_blk;

	// request unpacking
	assign in_start = s_tdata[BLOCK_W-1:0];
	assign in_len   = s_tdata[BLOCK_W +: LEN_W];
	assign in_blk   = s_tdata[BLOCK_W+LEN_W +: BLOCK_W];
	assign s_tready = (word.act == A_ACCEPT);
	assign fire     = s_tvalid && s_tready;
	assign cur_blk  = cursor_q[BLOCK_W-1:0];

	// status terms
	always_comb begin
		cur_busy   = (cursor_q < CUR_W'(NUM_BLOCKS)) && map_q[cur_blk];
		cur_more   = (END_W'(cursor_q) + END_W'(1)) < end_q;
		st_oor     = {1'b0, st_q} >= CUR_W'(NUM_BLOCKS);
		rd_more    = (rd_ptr_q + CNT_W'(1)) < pcount_q;
		wants_emit = (word.emit != E_NONE) && !((word.emit == E_HOLD) && cur_busy);
		stall      = wants_emit && out_valid_q && !m_tready;
		emit_now   = go && wants_emit;

		flags.fire      = fire;
		flags.cmd       = cmd_t'(s_tuser);
		flags.list_open = list_open_q;
		flags.cont_bad  = st_oor || (len_q == '0) || (end_q > END_W'(NUM_BLOCKS));
		flags.link_bad  = st_oor || (len_q == '0);
		flags.st_oor    = st_oor;
		flags.cur_busy  = cur_busy;
		flags.cur_more  = cur_more;
		flags.link_done = (cursor_q >= CUR_W'(NUM_BLOCKS)) || (cnt_q >= len_q);
		flags.fin       = fin_q;
		flags.list_bad  = ({1'b0, blk_q} >= CUR_W'(NUM_BLOCKS)) ||
			(pcount_q >= CNT_W'(MAX_LIST));
		flags.conflict  = conflict_q;
		flags.rd_more   = rd_more;
		flags.stall     = stall;
	end

	// bitmap and open list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q       <= '0;
			pmap_q      <= '0;
			list_open_q <= 1'b0;
			conflict_q  <= 1'b0;
			pcount_q    <= '0;
		end else if (go) begin
			unique case (word.act)
				A_SET_INC: begin
					map_q[cur_blk] <= 1'b1;
				end
				A_LINK_STEP: begin
					if (!cur_busy) map_q[cur_blk] <= 1'b1;
				end
				A_OPEN: begin
					list_open_q <= 1'b1;
					conflict_q  <= 1'b0;
					pcount_q    <= '0;
					pmap_q      <= '0;
				end
				A_PUSH: begin
					conflict_q    <= conflict_q || map_q[blk_q] || (blk_q == pidx_q) ||
						pmap_q[blk_q];
					pmap_q[blk_q] <= 1'b1;
					pcount_q      <= pcount_q + CNT_W'(1);
				end
				A_IDX: begin
					map_q[pidx_q] <= 1'b1;
				end
				A_RD_EMIT: begin
					map_q[rd_data_q] <= 1'b1;
				end
				A_CLOSE: begin
					list_open_q <= 1'b0;
					conflict_q  <= 1'b0;
					pcount_q    <= '0;
					pmap_q      <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// request capture, cursor and counters
	always_ff @(posedge clk) begin
		if (go) begin
			unique case (word.act)
				A_ACCEPT: begin
					if (fire) begin
						st_q     <= in_start;
						len_q    <= in_len;
						blk_q    <= in_blk;
						fin_q    <= s_tlast;
						cursor_q <= {1'b0, in_start};
						cnt_q    <= '0;
						end_q    <= END_W'(in_start) + END_W'(in_len);
					end
				end
				A_INC, A_SET_INC: begin
					cursor_q <= cursor_q + CUR_W'(1);
				end
				A_LOAD_START: begin
					cursor_q <= {1'b0, st_q};
				end
				A_LINK_STEP: begin
					if (!cur_busy) begin
						hold_q <= cur_blk;
						cnt_q  <= cnt_q + LEN_W'(1);
					end
					cursor_q <= cursor_q + CUR_W'(1);
				end
				A_OPEN: begin
					pidx_q <= st_q;
				end
				A_IDX: begin
					rd_ptr_q <= '0;
				end
				A_RD_EMIT: begin
					rd_ptr_q <= rd_ptr_q + CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// list memory, one write or one registered read a cycle, both gated by go
	always_ff @(posedge clk) begin
		if (go && (word.act == A_PUSH)) begin
			list_mem[pcount_q[LIST_AW-1:0]] <= blk_q;
		end
		if (go && (word.act == A_RD)) begin
			rd_data_q <= list_mem[rd_ptr_q[LIST_AW-1:0]];
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_now) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (emit_now) begin
			unique case (word.emit)
				E_CUR: begin
					out_status_q <= ST_OK;
					out_block_q  <= cur_blk;
					out_last_q   <= !cur_more;
				end
				E_HOLD: begin
					out_status_q <= ST_OK;
					out_block_q  <= hold_q;
					out_last_q   <= 1'b0;
				end
				E_LINK_LAST: begin
					out_status_q <= (cnt_q < len_q) ? ST_SHORT : ST_OK;
					out_block_q  <= hold_q;
					out_last_q   <= 1'b1;
				end
				E_PIDX: begin
					out_status_q <= ST_OK;
					out_block_q  <= pidx_q;
					out_last_q   <= 1'b0;
				end
				E_MEM: begin
					out_status_q <= ST_OK;
					out_block_q  <= rd_data_q;
					out_last_q   <= !rd_more;
				end
				default: begin
					out_status_q <= word.est;
					out_block_q  <= '0;
					out_last_q   <= 1'b1;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{(OUT_DATA_W-BLOCK_W){1'b0}}, out_block_q};
	assign m_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pcount_q <= CNT_W'(MAX_LIST))
		else $error("list fill count beyond list depth");

	a_closed_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!list_open_q |-> (pcount_q == '0) && !conflict_q && (pmap_q == '0))
		else $error("closed list still holds entries");

	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(go && (word.act == A_RD)) |-> (rd_ptr_q < pcount_q))
		else $error("list read beyond fill count");

	a_contig_free: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_now && (word.emit == E_CUR)) |-> !map_q[cur_blk])
		else $error("contiguous block reported while already busy");
`endif

endmodule

// ===== design/block_bitmap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// block_bitmap_allocator_unit : disk block allocator with bitmap
// Contiguous, indexed and linked allocation over a free-block bitmap,
// run by a microcoded sequencer over a plain datapath.
//
//   channel  dir  tdata                              tuser    tlast
//   s_*      in   start_block, length, list_block    cmd      list_last
//   m_*      out  block                              status   last
//
// One request beat is taken per program pass. Contiguous runs a busy
// scan then an allocate pass, one block a cycle each when the sequencer
// is not held; linked takes one cursor step a cycle when not held; the
// final list block alternates a list memory read and a result for each
// list entry.
// Reset clears the bitmap and list state at once; no clearing pass.
// A full result register with m_tready low holds any step that gives a result.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bba_pkg::IN_DATA_W-1:0]    s_tdata,  // start_block, length, list_block
	input  logic [bba_pkg::CMD_W-1:0]        s_tuser,  // cmd
	input  logic                             s_tlast,  // list_last
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bba_pkg::OUT_DATA_W-1:0]   m_tdata,  // block
	output logic [bba_pkg::STATUS_W-1:0]     m_tuser,  // status
	output logic                             m_tlast   // last
);
	import bba_pkg::*;

	ctrl_t  word;
	flags_t flags;
	logic   go;

	// program sequencer
	bba_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.word   (word),
		.go     (go)
	);

	// datapath and result register
	bba_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.word     (word),
		.go       (go),
		.flags    (flags)
	);

endmodule
